// ===== sv/bst_pkg.sv =====
package bst_pkg;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 7;
  localparam int KIND_W = 4;

  // token queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2a;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2f;
  localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3d;
  localparam logic [BYTE_W-1:0] CH_LT    = 8'h3c;
  localparam logic [BYTE_W-1:0] CH_GT    = 8'h3e;
  localparam logic [BYTE_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [BYTE_W-1:0] CH_LBRC  = 8'h7b;
  localparam logic [BYTE_W-1:0] CH_RBRC  = 8'h7d;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3b;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLUS    = 4'd0,
    KIND_MINUS   = 4'd1,
    KIND_STAR    = 4'd2,
    KIND_SLASH   = 4'd3,
    KIND_ASSIGN  = 4'd4,
    KIND_LESS    = 4'd5,
    KIND_GREATER = 4'd6,
    KIND_LPAREN  = 4'd7,
    KIND_RPAREN  = 4'd8,
    KIND_LBRACE  = 4'd9,
    KIND_RBRACE  = 4'd10,
    KIND_SEMI    = 4'd11,
    KIND_INTEGER = 4'd12,
    KIND_ERROR   = 4'd13,
    KIND_END     = 4'd14
  } tok_kind_t;

  // which tokens one queue entry carries: a flushed integer, then a second token
  typedef struct packed {
    logic int_v;
    logic tok_v;
  } ent_ctl_t;

  // map a byte to its single-character token; anything unknown is an error
  function automatic tok_kind_t single_kind(input logic [BYTE_W-1:0] b);
    tok_kind_t k;
    unique case (b)
      CH_PLUS:  k = KIND_PLUS;
      CH_MINUS: k = KIND_MINUS;
      CH_STAR:  k = KIND_STAR;
      CH_SLASH: k = KIND_SLASH;
      CH_EQ:    k = KIND_ASSIGN;
      CH_LT:    k = KIND_LESS;
      CH_GT:    k = KIND_GREATER;
      CH_LPAR:  k = KIND_LPAREN;
      CH_RPAR:  k = KIND_RPAREN;
      CH_LBRC:  k = KIND_LBRACE;
      CH_RBRC:  k = KIND_RBRACE;
      CH_SEMI:  k = KIND_SEMI;
      default:  k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/byte_stream_tokenizer.sv =====
// A token is queued with the byte that completes it; the out_ ports show the head.
// Throughput: one input beat per cycle while not full; a byte that flushes an integer and
// also gives a token yields two result beats, taken from the head entry one per cycle of pop.
// A four-entry token queue separates the classifier from the result side.
// Reset (rst_n low, synchronous): line 1, column 0, no open integer, queue empty.
module byte_stream_tokenizer
  import bst_pkg::*;
#(
  parameter int MAX_DIGITS  = 99,
  parameter int VALUE_BITS  = 32,
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [BYTE_W-1:0]      in_data_byte,
  input  logic                   in_end_of_input,
  output logic                   empty,
  input  logic                   pop,
  output logic [KIND_W-1:0]      out_token_kind,
  output logic [LINE_BITS-1:0]   out_start_line,
  output logic [COLUMN_BITS-1:0] out_start_column,
  output logic [BYTE_W-1:0]      out_token_byte,
  output logic [VALUE_BITS-1:0]  out_integer_value,
  output logic [CNT_W-1:0]       out_digit_count,
  output logic                   out_last_result
);

  // front -> back entry: control struct plus the two token payloads
  ent_ctl_t               ent_ctl;
  logic [LINE_BITS-1:0]   ent_int_line;
  logic [COLUMN_BITS-1:0] ent_int_col;
  logic [VALUE_BITS-1:0]  ent_int_val;
  logic [CNT_W-1:0]       ent_int_cnt;
  tok_kind_t              ent_tok_kind;
  logic [LINE_BITS-1:0]   ent_tok_line;
  logic [COLUMN_BITS-1:0] ent_tok_col;
  logic [BYTE_W-1:0]      ent_tok_byte;
  logic                   in_acc;

  // take a beat whenever the queue has room; the full check covers two-token items
  // too, since both tokens share one entry
  assign in_acc = push && !full;

  // front: classify the byte, advance line/column, accumulate integer digits
  bst_front #(
    .MAX_DIGITS (MAX_DIGITS),
    .VALUE_BITS (VALUE_BITS),
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_i     (in_acc),
    .byte_i    (in_data_byte),
    .eoi_i     (in_end_of_input),
    .ctl_o     (ent_ctl),
    .int_line_o(ent_int_line),
    .int_col_o (ent_int_col),
    .int_val_o (ent_int_val),
    .int_cnt_o (ent_int_cnt),
    .tok_kind_o(ent_tok_kind),
    .tok_line_o(ent_tok_line),
    .tok_col_o (ent_tok_col),
    .tok_byte_o(ent_tok_byte)
  );

  // back: hold token entries and drain them one result beat at a time
  bst_back #(
    .VALUE_BITS (VALUE_BITS),
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_ctl_i  (ent_ctl),
    .int_line_i(ent_int_line),
    .int_col_i (ent_int_col),
    .int_val_i (ent_int_val),
    .int_cnt_i (ent_int_cnt),
    .tok_kind_i(ent_tok_kind),
    .tok_line_i(ent_tok_line),
    .tok_col_i (ent_tok_col),
    .tok_byte_i(ent_tok_byte),
    .pop_i     (pop),
    .full_o    (full),
    .empty_o   (empty),
    .kind_o    (out_token_kind),
    .line_o    (out_start_line),
    .col_o     (out_start_column),
    .byte_o    (out_token_byte),
    .val_o     (out_integer_value),
    .cnt_o     (out_digit_count),
    .last_o    (out_last_result)
  );

endmodule

// ===== sv/bst_front.sv =====
module bst_front
  import bst_pkg::*;
#(
  parameter int MAX_DIGITS  = 99,
  parameter int VALUE_BITS  = 32,
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   acc_i,
  input  logic [BYTE_W-1:0]      byte_i,
  input  logic                   eoi_i,
  output ent_ctl_t               ctl_o,
  output logic [LINE_BITS-1:0]   int_line_o,
  output logic [COLUMN_BITS-1:0] int_col_o,
  output logic [VALUE_BITS-1:0]  int_val_o,
  output logic [CNT_W-1:0]       int_cnt_o,
  output tok_kind_t              tok_kind_o,
  output logic [LINE_BITS-1:0]   tok_line_o,
  output logic [COLUMN_BITS-1:0] tok_col_o,
  output logic [BYTE_W-1:0]      tok_byte_o
);

  logic [LINE_BITS-1:0]   line_r, line_nxt, line_mv;
  logic [COLUMN_BITS-1:0] col_r, col_nxt, col_mv;
  logic                   crp_r, crp_nxt;
  logic                   in_int_r, in_int_nxt;
  logic [VALUE_BITS-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]       dig_r, dig_nxt;
  logic [LINE_BITS-1:0]   sline_r, sline_nxt;
  logic [COLUMN_BITS-1:0] scol_r, scol_nxt;

  logic                   is_digit, is_nl, is_ws;
  logic [VALUE_BITS+3:0]  acc_ten;
  logic [VALUE_BITS-1:0]  acc_add;

  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign is_nl    = (byte_i == CH_LF) || (byte_i == CH_CR);
  assign is_ws    = is_nl || (byte_i == CH_SPACE) || (byte_i == CH_TAB);

  // acc * 10 + digit; any carry out of the value width means saturate
  assign acc_ten = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
                 + {{VALUE_BITS{1'b0}}, byte_i[3:0]};
  assign acc_add = (|acc_ten[VALUE_BITS+3:VALUE_BITS]) ? {VALUE_BITS{1'b1}}
                                                      : acc_ten[VALUE_BITS-1:0];

  always_comb begin
    line_mv = line_r;
    col_mv  = col_r;
    if (is_nl) begin
      if (line_r != {LINE_BITS{1'b1}}) line_mv = line_r + LINE_BITS'(1);
      col_mv = '0;
    end else if (col_r != {COLUMN_BITS{1'b1}}) begin
      col_mv = col_r + COLUMN_BITS'(1);
    end
  end

  always_comb begin
    line_nxt   = line_r;
    col_nxt    = col_r;
    crp_nxt    = crp_r;
    in_int_nxt = in_int_r;
    acc_nxt    = acc_r;
    dig_nxt    = dig_r;
    sline_nxt  = sline_r;
    scol_nxt   = scol_r;
    ctl_o      = '0;
    tok_kind_o = KIND_END;
    tok_byte_o = '0;
    if (acc_i) begin
      priority if (eoi_i) begin
        // flush, end token at current position, then back to reset values
        ctl_o.int_v = in_int_r;
        ctl_o.tok_v = 1'b1;
        line_nxt    = LINE_BITS'(1);
        col_nxt     = '0;
        crp_nxt     = 1'b0;
        in_int_nxt  = 1'b0;
        acc_nxt     = '0;
        dig_nxt     = '0;
        sline_nxt   = LINE_BITS'(1);
        scol_nxt    = '0;
      end else if (crp_r && (byte_i == CH_LF)) begin
        crp_nxt = 1'b0;
      end else if (in_int_r && is_digit) begin
        crp_nxt = 1'b0;
        line_nxt = line_mv;
        col_nxt  = col_mv;
        if (dig_r < CNT_W'(MAX_DIGITS)) begin
          dig_nxt = dig_r + CNT_W'(1);
          acc_nxt = acc_add;
        end
      end else begin
        ctl_o.int_v = in_int_r;
        in_int_nxt  = 1'b0;
        acc_nxt     = '0;
        dig_nxt     = '0;
        line_nxt    = line_mv;
        col_nxt     = col_mv;
        crp_nxt     = (byte_i == CH_CR);
        priority if (is_ws) begin
          // no token
        end else if (is_digit) begin
          in_int_nxt = 1'b1;
          acc_nxt    = VALUE_BITS'(byte_i[3:0]);
          dig_nxt    = CNT_W'(1);
          sline_nxt  = line_r;
          scol_nxt   = col_r;
        end else begin
          ctl_o.tok_v = 1'b1;
          tok_kind_o  = single_kind(byte_i);
          tok_byte_o  = byte_i;
        end
      end
    end
  end

  assign int_line_o = sline_r;
  assign int_col_o  = scol_r;
  assign int_val_o  = acc_r;
  assign int_cnt_o  = dig_r;
  assign tok_line_o = line_r;
  assign tok_col_o  = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r   <= LINE_BITS'(1);
      col_r    <= '0;
      crp_r    <= 1'b0;
      in_int_r <= 1'b0;
      acc_r    <= '0;
      dig_r    <= '0;
      sline_r  <= LINE_BITS'(1);
      scol_r   <= '0;
    end else begin
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      crp_r    <= crp_nxt;
      in_int_r <= in_int_nxt;
      acc_r    <= acc_nxt;
      dig_r    <= dig_nxt;
      sline_r  <= sline_nxt;
      scol_r   <= scol_nxt;
    end
  end

  a_eoi_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_i && eoi_i) |=> (line_r == LINE_BITS'(1)) && !in_int_r && !crp_r)
    else $error("end mark did not restore position state");

  a_cr_no_int: assert property (@(posedge clk) disable iff (!rst_n)
    crp_r |-> !in_int_r)
    else $error("integer open while CR pending");

endmodule

// ===== sv/bst_back.sv =====
module bst_back
  import bst_pkg::*;
#(
  parameter int VALUE_BITS  = 32,
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ent_ctl_t               wr_ctl_i,
  input  logic [LINE_BITS-1:0]   int_line_i,
  input  logic [COLUMN_BITS-1:0] int_col_i,
  input  logic [VALUE_BITS-1:0]  int_val_i,
  input  logic [CNT_W-1:0]       int_cnt_i,
  input  tok_kind_t              tok_kind_i,
  input  logic [LINE_BITS-1:0]   tok_line_i,
  input  logic [COLUMN_BITS-1:0] tok_col_i,
  input  logic [BYTE_W-1:0]      tok_byte_i,
  input  logic                   pop_i,
  output logic                   full_o,
  output logic                   empty_o,
  output logic [KIND_W-1:0]      kind_o,
  output logic [LINE_BITS-1:0]   line_o,
  output logic [COLUMN_BITS-1:0] col_o,
  output logic [BYTE_W-1:0]      byte_o,
  output logic [VALUE_BITS-1:0]  val_o,
  output logic [CNT_W-1:0]       cnt_o,
  output logic                   last_o
);

  ent_ctl_t               q_ctl      [QDEPTH];
  logic [LINE_BITS-1:0]   q_int_line [QDEPTH];
  logic [COLUMN_BITS-1:0] q_int_col  [QDEPTH];
  logic [VALUE_BITS-1:0]  q_int_val  [QDEPTH];
  logic [CNT_W-1:0]       q_int_cnt  [QDEPTH];
  tok_kind_t              q_tok_kind [QDEPTH];
  logic [LINE_BITS-1:0]   q_tok_line [QDEPTH];
  logic [COLUMN_BITS-1:0] q_tok_col  [QDEPTH];
  logic [BYTE_W-1:0]      q_tok_byte [QDEPTH];

  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              sel_r, sel_nxt;
  logic              wr_en, deq, show_int;
  ent_ctl_t          hctl;

  assign wr_en   = wr_ctl_i.int_v || wr_ctl_i.tok_v;
  assign full_o  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_r == '0);
  assign hctl    = q_ctl[rp_r];

  // integer goes first; sel_r marks that it has already left
  assign show_int = hctl.int_v && !sel_r;
  assign last_o   = show_int ? !hctl.tok_v : 1'b1;
  assign kind_o   = show_int ? KIND_INTEGER : q_tok_kind[rp_r];
  assign line_o   = show_int ? q_int_line[rp_r] : q_tok_line[rp_r];
  assign col_o    = show_int ? q_int_col[rp_r] : q_tok_col[rp_r];
  assign byte_o   = show_int ? '0 : q_tok_byte[rp_r];
  assign val_o    = show_int ? q_int_val[rp_r] : '0;
  assign cnt_o    = show_int ? q_int_cnt[rp_r] : '0;

  always_comb begin
    sel_nxt = sel_r;
    deq     = 1'b0;
    if (pop_i && !empty_o) begin
      if (last_o) begin
        deq     = 1'b1;
        sel_nxt = 1'b0;
      end else begin
        sel_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_ctl[wp_r]      <= wr_ctl_i;
      q_int_line[wp_r] <= int_line_i;
      q_int_col[wp_r]  <= int_col_i;
      q_int_val[wp_r]  <= int_val_i;
      q_int_cnt[wp_r]  <= int_cnt_i;
      q_tok_kind[wp_r] <= tok_kind_i;
      q_tok_line[wp_r] <= tok_line_i;
      q_tok_col[wp_r]  <= tok_col_i;
      q_tok_byte[wp_r] <= tok_byte_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      if (wr_en) wp_r <= wp_r + QPTR_W'(1);
      if (deq)   rp_r <= rp_r + QPTR_W'(1);
      if (wr_en && !deq)      cnt_r <= cnt_r + QCNT_W'(1);
      else if (deq && !wr_en) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("token queue overfilled");

  a_sel_pair: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (!empty_o && hctl.int_v && hctl.tok_v))
    else $error("second-token select without a two-token entry");

endmodule
